// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types, constants and the elaboration-time sine series for the
// windowed-sinc decimator.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;

    // Q30 fixed point constants used while building the coefficient table
    localparam logic [127:0] Q30_ONE = 128'd1 << 30;
    localparam logic [127:0] PI_Q30  = 128'd3373259426;

    // Taylor term divisors (2j)(2j+1), j = 1..39
    localparam int unsigned SERIES_DIV [39] = '{
        6, 20, 42, 72, 110, 156, 210, 272, 342, 420,
        506, 600, 702, 812, 930, 1056, 1190, 1332, 1482, 1640,
        1806, 1980, 2162, 2352, 2550, 2756, 2970, 3192, 3422, 3660,
        3906, 4160, 4422, 4692, 4970, 5256, 5550, 5852, 6162
    };

    // Controller to datapath commands
    typedef struct packed {
        logic write;   // take the input sample into the delay line
        logic start;   // clear accumulator, arm tap sweep at oldest entry
        logic issue;   // read one tap and advance
        logic finish;  // load output register from accumulator
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic phase_last;  // current sample completes a decimation phase
        logic last_tap;    // tap sweep is on its final entry
        logic pipe_busy;   // MAC pipeline still holds products
        logic out_free;    // output register can take a new result
    } status_t;

    // sin(x) in Q30 for x in (0, pi/2) by Taylor series, clamped at zero.
    // Terms past the first zero term stay zero, so the full sweep matches
    // an early stop.
    function automatic logic [127:0] taylor_sin_q30(input logic [127:0] x);
        logic [127:0]        x2;
        logic [127:0]        term;
        logic signed [129:0] sum;
        int                  j;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed({2'b00, x});
        for (j = 1; j < 40; j++) begin
            term = ((term * x2) >> 30) / SERIES_DIV[j - 1];
            if (j[0]) begin
                sum = sum - $signed({2'b00, term});
            end
            else begin
                sum = sum + $signed({2'b00, term});
            end
        end
        return (sum < 0) ? 128'd0 : sum[127:0];
    endfunction

endpackage

// File: sv/sinc_fir_decimator.sv
// Sequence: a sample that completes a decimation phase starts a sweep of
//   all TAPS entries (TAPS = 2*ZERO_CROSSINGS*RATIO+1) into the MAC.
// Throughput: one sample per cycle inside a phase; the completing sample
//   holds the input through the sweep, drain and result hand-off, set by the
//   single MAC unit reading one tap per cycle from the delay-line memory port.
// Reset: asynchronous, clears pointers, counters and the delay-line fill.
// ----------------------------------------------------------------------------
// sinc_fir_decimator
// Windowed-sinc FIR decimator: one 16-bit sample per transaction in, one
// filtered 16-bit result out every RATIO samples, with an end-of-block flag.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sinc_fir_decimator #(
    parameter int RATIO          = 4,
    parameter int ZERO_CROSSINGS = 4,
    parameter int BLOCK_OUTPUTS  = 128,
    parameter int COEF_FRAC_BITS = 17
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // sample channel
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  logic signed [sfd_pkg::SAMPLE_W-1:0] sample,
    // result channel
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [sfd_pkg::SAMPLE_W-1:0] filtered_value,
    output logic                                block_end
);

    // Controller and datapath talk only through these two bundles.
    //   cmd.write  : sample transaction taken into the delay line
    //   cmd.start  : phase complete, sweep from the oldest entry
    //   cmd.issue  : one tap per cycle into the MAC pipeline
    //   cmd.finish : accumulator scaled, rounded toward zero, saturated,
    //                and parked in the output register
    sfd_pkg::cmd_t    cmd;
    sfd_pkg::status_t status;

    sfd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .status       (status),
        .cmd          (cmd)
    );

    // The output register decouples the sides: a finished result may sit
    // stalled while the next phase's samples are taken in.
    sfd_datapath #(
        .RATIO          (RATIO),
        .ZERO_CROSSINGS (ZERO_CROSSINGS),
        .BLOCK_OUTPUTS  (BLOCK_OUTPUTS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .sample         (sample),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .filtered_value (filtered_value),
        .block_end      (block_end)
    );

    // No sample may land in the delay line while products are in flight.
    `ASSERT_IMPL(a_no_write_in_mac, clk, rst_n, status.pipe_busy, !cmd.write, "write during MAC")
    // The accumulator is complete and the output slot free before hand-off.
    `ASSERT_IMPL(a_finish_safe, clk, rst_n, cmd.finish, (!status.pipe_busy && status.out_free), "early finish")
    // A finished result is presented on the next cycle.
    `ASSERT_NEXT(a_finish_shows, clk, rst_n, cmd.finish, result_valid, "result not presented")

endmodule

// File: sv/sfd_ctrl.sv
// ----------------------------------------------------------------------------
// sfd_ctrl
// Sequencer: sample intake, tap sweep, pipeline drain and result hand-off.
// ----------------------------------------------------------------------------
module sfd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_stall,
    input  sfd_pkg::status_t status,
    output sfd_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MAC   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_FIN   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

    assign sample_stall = (state_reg != S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (sample_valid) begin
                    cmd.write = 1'b1;
                    if (status.phase_last) begin
                        cmd.start  = 1'b1;
                        state_next = S_MAC;
                    end
                end
            end
            S_MAC:
            begin
                cmd.issue = 1'b1;
                if (status.last_tap) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!status.pipe_busy) begin
                    if (status.out_free) begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                    else begin
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN:
            begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/sfd_datapath.sv
// ----------------------------------------------------------------------------
// sfd_datapath
// Delay-line memory, coefficient ROM, MAC pipeline and output register.
// ----------------------------------------------------------------------------
module sfd_datapath #(
    parameter int RATIO          = 4,
    parameter int ZERO_CROSSINGS = 4,
    parameter int BLOCK_OUTPUTS  = 128,
    parameter int COEF_FRAC_BITS = 17
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sfd_pkg::cmd_t                       cmd,
    output sfd_pkg::status_t                    status,
    input  logic signed [sfd_pkg::SAMPLE_W-1:0] sample,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [sfd_pkg::SAMPLE_W-1:0] filtered_value,
    output logic                                block_end
);

    localparam int HALF_SPAN = ZERO_CROSSINGS * RATIO;
    localparam int TAPS      = 2 * HALF_SPAN + 1;
    localparam int PTR_W     = $clog2(TAPS);
    localparam int FILL_W    = $clog2(TAPS + 1);
    localparam int PH_W      = $clog2(RATIO);
    localparam int OCNT_W    = $clog2(BLOCK_OUTPUTS + 1);
    localparam int COEF_W    = COEF_FRAC_BITS + 1;
    localparam int PROD_W    = sfd_pkg::SAMPLE_W + COEF_W;
    localparam int ACC_W     = PROD_W + $clog2(TAPS);
    localparam int QUO_W     = ACC_W - COEF_FRAC_BITS;

    localparam logic [127:0] R1 = 128'(RATIO);
    localparam logic [127:0] R2 = 128'(2 * RATIO);
    localparam logic [127:0] W1 = 128'(2 * HALF_SPAN);
    localparam logic [127:0] W2 = 128'(4 * HALF_SPAN);
    localparam logic [127:0] RND_HALF = 128'd1 << (59 - COEF_FRAC_BITS);
    localparam logic [127:0] CENTRE =
        ((128'd1 << (COEF_FRAC_BITS + 1)) + R1) / R2;

    localparam logic signed [QUO_W-1:0] QMAX = QUO_W'(sfd_pkg::SAMPLE_MAX);
    localparam logic signed [QUO_W-1:0] QMIN = QUO_W'(sfd_pkg::SAMPLE_MIN);

    // ------------------------------------------------------------------
    // Coefficient ROM: Hann-windowed sinc, built at elaboration
    // ------------------------------------------------------------------
    logic signed [COEF_W-1:0] coef_tab [TAPS];

    for (genvar k = 0; k < TAPS; k++) begin : g_coef
        localparam int           N      = k - HALF_SPAN;
        localparam int           ANI    = (N < 0) ? -N : N;
        localparam logic [127:0] AN_DIV = 128'((ANI == 0) ? 1 : ANI);
        // sinc numerator: sin(pi*|n|/RATIO)
        localparam logic [127:0] SM0  = 128'(ANI) % R2;
        localparam logic         SNEG = (SM0 >= R1);
        localparam logic [127:0] SM1  = SNEG ? (SM0 - R1) : SM0;
        localparam logic [127:0] SM2  = ((2 * SM1) > R1) ? (R1 - SM1) : SM1;
        localparam logic [127:0] SMAG =
            (SM2 == 0) ? 128'd0 :
            ((2 * SM2) == R1) ? sfd_pkg::Q30_ONE :
            sfd_pkg::taylor_sin_q30((sfd_pkg::PI_Q30 * SM2) / R1);
        localparam logic [127:0] S = (SMAG << 30) / (sfd_pkg::PI_Q30 * AN_DIV);
        // window: cos(pi*k/HALF_SPAN) as sin(pi*(2k+HALF_SPAN)/(2*HALF_SPAN))
        localparam logic [127:0] CM0  = 128'(2 * k + HALF_SPAN) % W2;
        localparam logic         CNEG = (CM0 >= W1);
        localparam logic [127:0] CM1  = CNEG ? (CM0 - W1) : CM0;
        localparam logic [127:0] CM2  = ((2 * CM1) > W1) ? (W1 - CM1) : CM1;
        localparam logic [127:0] CMAG =
            (CM2 == 0) ? 128'd0 :
            ((2 * CM2) == W1) ? sfd_pkg::Q30_ONE :
            sfd_pkg::taylor_sin_q30((sfd_pkg::PI_Q30 * CM2) / W1);
        localparam logic [127:0] W = CNEG ? ((sfd_pkg::Q30_ONE + CMAG) / 2)
                                          : ((sfd_pkg::Q30_ONE - CMAG) / 2);
        localparam logic [127:0] MAG = ((S * W) + RND_HALF) >> (60 - COEF_FRAC_BITS);
        localparam logic [COEF_W-1:0] CMAG_T = COEF_W'((N == 0) ? CENTRE : MAG);
        localparam logic [COEF_W-1:0] CVAL   =
            ((N != 0) && SNEG) ? (~CMAG_T + COEF_W'(1)) : CMAG_T;

        assign coef_tab[k] = $signed(CVAL);
    end

    // ------------------------------------------------------------------
    // Control counters
    // ------------------------------------------------------------------
    logic [PTR_W-1:0]  wptr_reg;
    logic [PTR_W-1:0]  wptr_inc;
    logic [FILL_W-1:0] fill_reg;
    logic [PH_W-1:0]   phase_reg;
    logic [PTR_W-1:0]  raddr_reg;
    logic [PTR_W-1:0]  tap_reg;
    logic [OCNT_W-1:0] ocnt_reg;
    logic              rd_vld_reg;
    logic              mul_vld_reg;
    logic              out_valid_reg;
    logic              out_last;

    assign wptr_inc = (wptr_reg == PTR_W'(TAPS - 1)) ? '0 : (wptr_reg + PTR_W'(1));
    assign out_last = (ocnt_reg == OCNT_W'(BLOCK_OUTPUTS - 1));

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wptr_reg      <= '0;
            fill_reg      <= '0;
            phase_reg     <= '0;
            raddr_reg     <= '0;
            tap_reg       <= '0;
            ocnt_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            mul_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (cmd.write) begin
                wptr_reg  <= wptr_inc;
                phase_reg <= status.phase_last ? '0 : (phase_reg + PH_W'(1));
                if (fill_reg != FILL_W'(TAPS)) begin
                    fill_reg <= fill_reg + FILL_W'(1);
                end
            end
            if (cmd.start) begin
                raddr_reg <= wptr_inc;
                tap_reg   <= '0;
            end
            else if (cmd.issue) begin
                raddr_reg <= (raddr_reg == PTR_W'(TAPS - 1)) ? '0
                                                             : (raddr_reg + PTR_W'(1));
                tap_reg   <= status.last_tap ? '0 : (tap_reg + PTR_W'(1));
            end
            rd_vld_reg  <= cmd.issue;
            mul_vld_reg <= rd_vld_reg;
            if (cmd.finish) begin
                out_valid_reg <= 1'b1;
                ocnt_reg      <= out_last ? '0 : (ocnt_reg + OCNT_W'(1));
            end
            else if (out_valid_reg && !result_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Delay-line memory; entries at or past the fill count read as zero
    // ------------------------------------------------------------------
    logic signed [sfd_pkg::SAMPLE_W-1:0] dly_mem [TAPS];
    logic signed [sfd_pkg::SAMPLE_W-1:0] rd_data_reg;
    logic                                rd_ok_reg;
    logic signed [COEF_W-1:0]            coef_reg;

    always_ff @(posedge clk) begin
        if (cmd.write) begin
            dly_mem[wptr_reg] <= sample;
        end
        if (cmd.issue) begin
            rd_data_reg <= dly_mem[raddr_reg];
            rd_ok_reg   <= (FILL_W'(raddr_reg) < fill_reg);
            coef_reg    <= coef_tab[tap_reg];
        end
    end

    // ------------------------------------------------------------------
    // MAC pipeline and result formatting
    // ------------------------------------------------------------------
    logic signed [sfd_pkg::SAMPLE_W-1:0] tap_val;
    logic signed [PROD_W-1:0]            mul_res;
    logic signed [PROD_W-1:0]            prod_reg;
    logic signed [ACC_W-1:0]             acc_reg;
    logic signed [QUO_W-1:0]             quo_floor;
    logic signed [QUO_W-1:0]             quo;
    logic signed [sfd_pkg::SAMPLE_W-1:0] sat_val;
    logic signed [sfd_pkg::SAMPLE_W-1:0] out_value_reg;
    logic                                out_end_reg;

    assign tap_val = rd_ok_reg ? rd_data_reg : '0;
    assign mul_res = tap_val * coef_reg;

    // truncate toward zero: floor, then bump negatives with a nonzero fraction
    assign quo_floor = $signed(acc_reg[ACC_W-1:COEF_FRAC_BITS]);
    assign quo = quo_floor +
        QUO_W'(acc_reg[ACC_W-1] && (acc_reg[COEF_FRAC_BITS-1:0] != '0));

    always_comb begin
        priority if (quo > QMAX) begin
            sat_val = sfd_pkg::SAMPLE_W'(sfd_pkg::SAMPLE_MAX);
        end
        else if (quo < QMIN) begin
            sat_val = sfd_pkg::SAMPLE_W'(sfd_pkg::SAMPLE_MIN);
        end
        else begin
            sat_val = quo[sfd_pkg::SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk) begin
        if (rd_vld_reg) begin
            prod_reg <= mul_res;
        end
        if (cmd.start) begin
            acc_reg <= '0;
        end
        else if (mul_vld_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (cmd.finish) begin
            out_value_reg <= sat_val;
            out_end_reg   <= out_last;
        end
    end

    assign status.phase_last = (phase_reg == PH_W'(RATIO - 1));
    assign status.last_tap   = (tap_reg == PTR_W'(TAPS - 1));
    assign status.pipe_busy  = rd_vld_reg || mul_vld_reg;
    assign status.out_free   = !out_valid_reg || !result_stall;

    assign result_valid   = out_valid_reg;
    assign filtered_value = out_value_reg;
    assign block_end      = out_end_reg;

endmodule
